/* rtl/core/mpe_sec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_sec_pkg
// Types and constants shared by the MPE section datagram extractor.
// ----------------------------------------------------------------------------
package mpe_sec_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       payload_start;
    logic       unit_start;
    logic [7:0] payload_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ip_byte;
    logic [11:0] ip_length;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POINTER,
    PH_START,
    PH_BODY_U,
    PH_BODY_C,
    PH_SKIP
  } phase_t;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_KEEP = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  localparam logic       CFG_TABLE_ID = 1'b0;
  localparam logic       CFG_PROTOCOL = 1'b1;

  localparam logic [7:0] TABLE_ID_RST = 8'h3E;
  localparam logic [7:0] PROTOCOL_RST = 8'd17;
  localparam logic [7:0] STUFF_BYTE   = 8'hFF;
  localparam logic [3:0] IPV4_VERSION = 4'd4;
  localparam int         HDR_LEN      = 12;
  localparam int         CRC_LEN      = 4;
  localparam int         PROTO_POS    = HDR_LEN + 9;
  localparam int         MIN_SECT_LEN = 28 + HDR_LEN + CRC_LEN - 3;
  localparam logic [11:0] LEN_ADJ     = 12'(HDR_LEN + CRC_LEN - 3);

  localparam int         QUEUE_DEPTH  = 4;

endpackage

/* rtl/core/mpe_section_ip_extractor_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_section_ip_extractor_unit
// Reassembles MPE sections from transport-stream payload bytes and streams
// out the datagram bytes of matching sections, each closed by a keep or
// drop marker.
//
//   Channel  Direction  Request
//   in_      input      one payload byte with packet start flags
//   out_     output     datagram byte, keep marker or drop marker
//   cfg_     input      write of table id or IP protocol register
//
// One byte is accepted per cycle while in_stall is low; its results enter
// the result queue on the same edge and leave on out_ one per cycle while
// out_stall is low. The parser state update for one byte is combinational
// and registered. in_stall rises when the four-entry result queue has fewer
// than two free entries, so a stalled output backs up into the input after
// a few bytes. Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module mpe_section_ip_extractor_unit #(
  parameter int TS_PAYLOAD_MAX = 184
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mpe_sec_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mpe_sec_pkg::out_item_t out_data,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data
);
  import mpe_sec_pkg::*;

  push_t push;
  logic  full;
  logic  acc;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  mpe_sec_front #(
    .TS_PAYLOAD_MAX(TS_PAYLOAD_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  mpe_sec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/mpe_sec_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_sec_front
// Section parser: pointer handling, section reassembly and datagram
// classification. Produces up to two results for each accepted byte.
// ----------------------------------------------------------------------------
module mpe_sec_front #(
  parameter int TS_PAYLOAD_MAX = 184
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  mpe_sec_pkg::in_item_t item,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_data,
  output mpe_sec_pkg::push_t    push
);
  import mpe_sec_pkg::*;

  localparam logic [7:0] PMAX = 8'(TS_PAYLOAD_MAX);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  table_id_r, protocol_r;
  logic [7:0]  pointer_left_r, pointer_left_nxt;
  logic [7:0]  payload_left_r, payload_left_nxt;
  logic [12:0] section_pos_r, section_pos_nxt;
  logic [11:0] section_len_r, section_len_nxt;
  logic [3:0]  length_high_r, length_high_nxt;
  logic        in_section_r, in_section_nxt;
  logic        emitting_r, emitting_nxt;
  logic        version_ok_r, version_ok_nxt;
  logic        protocol_ok_r, protocol_ok_nxt;

  logic [7:0]  b;
  logic [7:0]  plen;
  logic        ptr_valid;

  logic        pre_abort, do_start, do_feed, post_abort;
  out_item_t   res [2];
  logic [1:0]  cnt;
  logic [13:0] pos14, end14;

  assign b = item.data_byte;

  always_comb begin
    plen = item.payload_bytes;
    if (plen == 8'd0) begin
      plen = 8'd1;
    end
    if (plen > PMAX) begin
      plen = PMAX;
    end
    ptr_valid = (b != 8'd0) && (b <= plen - 8'd1);
  end

  always_comb begin
    pointer_left_nxt = pointer_left_r;
    payload_left_nxt = payload_left_r;
    section_pos_nxt  = section_pos_r;
    section_len_nxt  = section_len_r;
    length_high_nxt  = length_high_r;
    in_section_nxt   = in_section_r;
    emitting_nxt     = emitting_r;
    version_ok_nxt   = version_ok_r;
    protocol_ok_nxt  = protocol_ok_r;
    pre_abort  = 1'b0;
    do_start   = 1'b0;
    do_feed    = 1'b0;
    post_abort = 1'b0;
    cnt        = 2'd0;
    res[0]     = '0;
    res[1]     = '0;
    pos14      = '0;
    end14      = '0;

    if (acc) begin
      if (item.payload_start) begin
        payload_left_nxt = plen - 8'd1;
        if (item.unit_start) begin
          pre_abort        = !(ptr_valid && in_section_r);
          pointer_left_nxt = ptr_valid ? b : 8'd0;
        end else begin
          do_feed = in_section_r;
        end
      end else if (payload_left_r != 8'd0) begin
        payload_left_nxt = payload_left_r - 8'd1;
        unique case (phase_r)
          PH_POINTER: begin
            if (pointer_left_r != 8'd0) begin
              pointer_left_nxt = pointer_left_r - 8'd1;
            end
            do_feed    = in_section_r;
            post_abort = (pointer_left_nxt == 8'd0);
          end
          PH_START: begin
            do_start = (b != STUFF_BYTE);
            do_feed  = (b != STUFF_BYTE);
          end
          PH_BODY_U, PH_BODY_C: begin
            do_feed = in_section_r;
          end
          default: begin
          end
        endcase
      end

      if (pre_abort) begin
        if (in_section_nxt && emitting_nxt) begin
          res[cnt[0]] = '{kind: KIND_DROP, ip_byte: 8'd0,
                          ip_length: section_len_nxt - LEN_ADJ};
          cnt = cnt + 2'd1;
        end
        in_section_nxt  = 1'b0;
        emitting_nxt    = 1'b0;
        section_pos_nxt = '0;
      end

      if (do_start) begin
        in_section_nxt  = 1'b1;
        emitting_nxt    = 1'b0;
        section_pos_nxt = '0;
        version_ok_nxt  = 1'b0;
        protocol_ok_nxt = 1'b0;
      end

      if (do_feed) begin
        pos14 = {1'b0, section_pos_nxt};
        if (pos14 == 14'd0) begin
          emitting_nxt = (b == table_id_r);
        end else if (pos14 == 14'd1) begin
          length_high_nxt = b[3:0];
        end else if (pos14 == 14'd2) begin
          section_len_nxt = {length_high_nxt, b};
          if (section_len_nxt < 12'(MIN_SECT_LEN)) begin
            emitting_nxt = 1'b0;
          end
        end else begin
          if (pos14 == 14'(HDR_LEN)) begin
            version_ok_nxt = (b[7:4] == IPV4_VERSION);
          end
          if (pos14 == 14'(PROTO_POS)) begin
            protocol_ok_nxt = (b == protocol_r);
          end
        end
        end14 = {2'b00, section_len_nxt} + 14'd3;
        if (pos14 >= 14'd3 && emitting_nxt && pos14 >= 14'(HDR_LEN) &&
            pos14 + 14'(CRC_LEN) < end14) begin
          res[cnt[0]] = '{kind: KIND_BYTE, ip_byte: b, ip_length: 12'd0};
          cnt = cnt + 2'd1;
        end
        if (pos14 >= 14'd2 && pos14 + 14'd1 >= end14) begin
          if (emitting_nxt) begin
            res[cnt[0]] = '{kind: (version_ok_nxt && protocol_ok_nxt) ?
                                  KIND_KEEP : KIND_DROP,
                            ip_byte: 8'd0,
                            ip_length: section_len_nxt - LEN_ADJ};
            cnt = cnt + 2'd1;
          end
          in_section_nxt  = 1'b0;
          emitting_nxt    = 1'b0;
          section_pos_nxt = '0;
        end else begin
          section_pos_nxt = section_pos_nxt + 13'd1;
        end
      end

      if (post_abort) begin
        if (in_section_nxt && emitting_nxt) begin
          res[cnt[0]] = '{kind: KIND_DROP, ip_byte: 8'd0,
                          ip_length: section_len_nxt - LEN_ADJ};
          cnt = cnt + 2'd1;
        end
        in_section_nxt  = 1'b0;
        emitting_nxt    = 1'b0;
        section_pos_nxt = '0;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      if (item.payload_start) begin
        if (item.unit_start) begin
          phase_nxt = ptr_valid ? PH_POINTER : PH_START;
        end else if (in_section_r) begin
          phase_nxt = in_section_nxt ? PH_BODY_C : PH_SKIP;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end else if (payload_left_r == 8'd0) begin
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_POINTER: phase_nxt = post_abort ? PH_START : PH_POINTER;
          PH_START: begin
            if (b == STUFF_BYTE) begin
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = in_section_nxt ? PH_BODY_U : PH_START;
            end
          end
          PH_BODY_U:  phase_nxt = in_section_nxt ? PH_BODY_U : PH_START;
          PH_BODY_C:  phase_nxt = in_section_nxt ? PH_BODY_C : PH_SKIP;
          default:    phase_nxt = phase_r;
        endcase
      end
      if (payload_left_nxt == 8'd0) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_comb begin
    push.cnt   = cnt;
    push.item0 = res[0];
    push.item1 = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      table_id_r     <= TABLE_ID_RST;
      protocol_r     <= PROTOCOL_RST;
      pointer_left_r <= '0;
      payload_left_r <= '0;
      section_pos_r  <= '0;
      section_len_r  <= '0;
      length_high_r  <= '0;
      in_section_r   <= 1'b0;
      emitting_r     <= 1'b0;
      version_ok_r   <= 1'b0;
      protocol_ok_r  <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      pointer_left_r <= pointer_left_nxt;
      payload_left_r <= payload_left_nxt;
      section_pos_r  <= section_pos_nxt;
      section_len_r  <= section_len_nxt;
      length_high_r  <= length_high_nxt;
      in_section_r   <= in_section_nxt;
      emitting_r     <= emitting_nxt;
      version_ok_r   <= version_ok_nxt;
      protocol_ok_r  <= protocol_ok_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_TABLE_ID: table_id_r <= cfg_data;
          CFG_PROTOCOL: protocol_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/mpe_sec_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_sec_queue
// Result queue and output side: takes up to two results a cycle from the
// parser and presents one result a cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module mpe_sec_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mpe_sec_pkg::push_t     push,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mpe_sec_pkg::out_item_t out_data
);
  import mpe_sec_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  out_item_t       mem [QUEUE_DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rp_r];
  assign full      = (count_r > CW'(QUEUE_DEPTH - 2));

  always_comb begin
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp_r] <= push.item0;
    end
    if (push.cnt == 2'd2) begin
      mem[wp_r + AW'(1)] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + AW'(push.cnt);
      rp_r    <= rp_r + AW'(pop);
      count_r <= count_nxt;
    end
  end

endmodule

/* bench/mpe_section_ip_extractor_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpe_section_ip_extractor_unit_tb
// Self-checking bench for the MPE section datagram extractor. Transport
// stream packets are built from sections with random content, mostly well
// formed and mixed with broken pointers, truncated packets, stray bytes and
// noise. Each accepted request is run through a bit-accurate section parser
// kept in the bench, and every datagram byte and end marker on the output is
// compared in order against it. Both channels idle and stall at random, and
// the register settings change between traffic phases while the block is
// idle.
// ----------------------------------------------------------------------------
module mpe_section_ip_extractor_unit_tb;
  import mpe_sec_pkg::*;

  localparam int PAYLOAD_MAX = 184;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_index = CFG_TABLE_ID;
  logic [7:0] cfg_data = '0;

  in_item_t   pending_q[$];
  out_item_t  dgram_q[$];
  logic [7:0] sect_bytes[$];
  out_item_t  want_item;
  int         pushed_cnt = 0;
  int         fault_cnt  = 0;
  int         sent_cnt   = 0;
  int         send_gap   = 0;
  bit         send_calm  = 1'b0;
  int         recv_cnt   = 0;
  int         recv_hold  = 0;
  bit         recv_calm  = 1'b0;

  logic [7:0]  cur_tid    = TABLE_ID_RST;
  logic [7:0]  cur_proto  = PROTOCOL_RST;
  phase_t      sec_phase  = PH_IDLE;
  logic [7:0]  ptr_left   = '0;
  logic [7:0]  pay_left   = '0;
  logic [12:0] sec_pos    = '0;
  logic [11:0] sec_len    = '0;
  logic [3:0]  len_hi     = '0;
  logic        sec_open   = 1'b0;
  logic        sec_emit   = 1'b0;
  logic        ver_good   = 1'b0;
  logic        proto_good = 1'b0;

  mpe_section_ip_extractor_unit #(
    .TS_PAYLOAD_MAX(PAYLOAD_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void emit_result(logic [1:0] k, logic [7:0] b, logic [11:0] l);
    out_item_t r;
    r.kind      = k;
    r.ip_byte   = b;
    r.ip_length = l;
    dgram_q.push_back(r);
  endfunction

  function automatic void close_section();
    sec_open = 1'b0;
    sec_emit = 1'b0;
    sec_pos  = '0;
  endfunction

  function automatic void abort_section();
    if (sec_open && sec_emit) emit_result(KIND_DROP, 8'h00, sec_len - LEN_ADJ);
    close_section();
  endfunction

  function automatic void section_byte(logic [7:0] b);
    int p;
    p = sec_pos;
    if (p == 0) begin
      sec_emit = (b == cur_tid);
    end else if (p == 1) begin
      len_hi = b[3:0];
    end else if (p == 2) begin
      sec_len = {len_hi, b};
      if (sec_len < MIN_SECT_LEN) sec_emit = 1'b0;
    end else begin
      if (p == HDR_LEN) ver_good = (b[7:4] == IPV4_VERSION);
      if (p == PROTO_POS) proto_good = (b == cur_proto);
      if (sec_emit && p >= HDR_LEN && p + CRC_LEN < int'(sec_len) + 3)
        emit_result(KIND_BYTE, b, 12'd0);
    end
    if (p >= 2 && p + 1 >= int'(sec_len) + 3) begin
      if (sec_emit)
        emit_result((ver_good && proto_good) ? KIND_KEEP : KIND_DROP, 8'h00,
                    sec_len - LEN_ADJ);
      close_section();
    end else begin
      sec_pos = 13'(p + 1);
    end
  endfunction

  function automatic void extract_step(in_item_t it);
    logic [7:0] b;
    int         plen;
    logic       ptr_ok;
    b    = it.data_byte;
    plen = it.payload_bytes;
    if (it.payload_start) begin
      if (plen == 0) plen = 1;
      if (plen > PAYLOAD_MAX) plen = PAYLOAD_MAX;
      pay_left = 8'(plen - 1);
      if (it.unit_start) begin
        ptr_ok = (b > 0 && b <= pay_left);
        if (!(ptr_ok && sec_open)) abort_section();
        if (ptr_ok) begin
          ptr_left  = b;
          sec_phase = PH_POINTER;
        end else begin
          ptr_left  = '0;
          sec_phase = PH_START;
        end
      end else if (sec_open) begin
        section_byte(b);
        sec_phase = sec_open ? PH_BODY_C : PH_SKIP;
      end else begin
        sec_phase = PH_SKIP;
      end
    end else begin
      if (pay_left == 0) begin
        sec_phase = PH_IDLE;
        return;
      end
      pay_left = pay_left - 8'd1;
      case (sec_phase)
        PH_POINTER: begin
          if (ptr_left > 0) ptr_left = ptr_left - 8'd1;
          if (sec_open) section_byte(b);
          if (ptr_left == 0) begin
            abort_section();
            sec_phase = PH_START;
          end
        end
        PH_START: begin
          if (b == STUFF_BYTE) begin
            sec_phase = PH_SKIP;
          end else begin
            close_section();
            sec_open   = 1'b1;
            ver_good   = 1'b0;
            proto_good = 1'b0;
            section_byte(b);
            sec_phase = sec_open ? PH_BODY_U : PH_START;
          end
        end
        PH_BODY_U, PH_BODY_C: begin
          if (sec_open) section_byte(b);
          if (!sec_open) sec_phase = (sec_phase == PH_BODY_U) ? PH_START : PH_SKIP;
        end
        default: ;
      endcase
    end
    if (pay_left == 0) sec_phase = PH_IDLE;
  endfunction

  task automatic push_req(logic [7:0] b, logic ps, logic us, logic [7:0] plen);
    in_item_t it;
    it.data_byte     = b;
    it.payload_start = ps;
    it.unit_start    = us;
    it.payload_bytes = plen;
    pending_q.push_back(it);
    pushed_cnt++;
  endtask

  // Modes: 0 clean, 1 long pointer, 2 short pointer, 3 pointer past the
  // payload, 4 truncated packet, 5 stray bytes after the payload.
  task automatic gen_packet(int flen, int mode);
    logic [7:0] pkt[$];
    logic       us;
    int         plen;
    int         ptr;
    int         slen;
    int         n;
    logic [7:0] b;
    plen = (flen == 0) ? 1 : ((flen > PAYLOAD_MAX) ? PAYLOAD_MAX : flen);
    us   = 1'b1;
    if (sect_bytes.size() > 0 && sect_bytes.size() >= plen) begin
      us = 1'b0;
      repeat (plen) pkt.push_back(sect_bytes.pop_front());
    end else begin
      ptr = sect_bytes.size();
      if (mode == 1) ptr = sect_bytes.size() + $urandom_range(1, 3);
      if (mode == 2 && sect_bytes.size() > 0) ptr = $urandom_range(0, sect_bytes.size() - 1);
      if (mode == 3) ptr = $urandom_range(plen, 255);
      pkt.push_back(8'(ptr));
      if (mode != 3) begin
        while (pkt.size() <= ptr && pkt.size() < plen)
          pkt.push_back((sect_bytes.size() > 0) ? sect_bytes.pop_front() : 8'($urandom));
      end
      sect_bytes.delete();
      while (pkt.size() < plen) begin
        if (sect_bytes.size() == 0) begin
          if ($urandom_range(0, 9) == 0) begin
            while (pkt.size() < plen) pkt.push_back(STUFF_BYTE);
          end else begin
            n = $urandom_range(0, 99);
            if (n < 70) slen = $urandom_range(MIN_SECT_LEN, MIN_SECT_LEN + 30);
            else if (n < 85) slen = $urandom_range(0, MIN_SECT_LEN - 1);
            else slen = $urandom_range(MIN_SECT_LEN, 500);
            sect_bytes.push_back(($urandom_range(0, 4) != 0) ? cur_tid : 8'($urandom_range(0, 254)));
            sect_bytes.push_back({4'($urandom), 4'(slen >> 8)});
            sect_bytes.push_back(8'(slen));
            for (int i = 3; i < slen + 3; i++) begin
              b = 8'($urandom);
              if (i == HDR_LEN && $urandom_range(0, 9) != 0) b[7:4] = IPV4_VERSION;
              if (i == PROTO_POS && $urandom_range(0, 4) != 0) b = cur_proto;
              sect_bytes.push_back(b);
            end
          end
        end
        while (sect_bytes.size() > 0 && pkt.size() < plen) pkt.push_back(sect_bytes.pop_front());
      end
    end
    n = pkt.size();
    if (mode == 4 && n > 1) begin
      n = $urandom_range(1, n - 1);
      sect_bytes.delete();
    end
    for (int i = 0; i < n; i++) begin
      if (i == 0) push_req(pkt[i], 1'b1, us, 8'(flen));
      else push_req(pkt[i], 1'b0, 1'($urandom), 8'($urandom));
    end
    if (mode == 5) begin
      repeat ($urandom_range(1, 4)) push_req(8'($urandom), 1'b0, 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_traffic(int count);
    int stop_at;
    int r;
    int flen;
    stop_at = pushed_cnt + count;
    while (pushed_cnt < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        repeat ($urandom_range(1, 8))
          push_req(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom), 8'($urandom));
      end else begin
        flen = $urandom_range(0, 99);
        if (flen < 60) flen = $urandom_range(8, 60);
        else if (flen < 80) flen = $urandom_range(61, PAYLOAD_MAX);
        else if (flen < 88) flen = PAYLOAD_MAX;
        else if (flen < 96) flen = $urandom_range(1, 7);
        else if (flen < 98) flen = 0;
        else flen = $urandom_range(PAYLOAD_MAX + 1, 255);
        gen_packet(flen, (r < 80) ? 0 : $urandom_range(1, 5));
      end
    end
  endtask

  task automatic wait_idle(int settle);
    while (pending_q.size() != 0 || dgram_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TABLE_ID) cur_tid = val;
    else cur_proto = val;
  endtask

  task automatic next_setting(logic [7:0] tid, logic [7:0] proto, int count);
    wait_idle(4);
    write_reg(CFG_TABLE_ID, tid);
    write_reg(CFG_PROTOCOL, proto);
    sect_bytes.delete();
    random_traffic(count);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        extract_step(in_data);
        pending_q.delete(0);
        sent_cnt++;
        if (sent_cnt % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
        send_gap = send_calm ? 0 : $urandom_range(0, 10);
      end else if (send_gap > 0) begin
        send_gap--;
      end
      if (send_gap == 0 && pending_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dgram_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("unexpected result: kind=%0d byte=%02h length=%0d",
                     out_data.kind, out_data.ip_byte, out_data.ip_length);
        end else begin
          want_item = dgram_q.pop_front();
          if (out_data.kind !== want_item.kind || out_data.ip_byte !== want_item.ip_byte ||
              out_data.ip_length !== want_item.ip_length) begin
            fault_cnt++;
            if (fault_cnt <= 10)
              $display("mismatch: expected kind=%0d byte=%02h length=%0d, got kind=%0d byte=%02h length=%0d",
                       want_item.kind, want_item.ip_byte, want_item.ip_length,
                       out_data.kind, out_data.ip_byte, out_data.ip_length);
          end
        end
        recv_cnt++;
        if (recv_cnt % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        recv_hold = recv_calm ? 0 : $urandom_range(0, 10);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end else if (!out_valid && !recv_calm && $urandom_range(0, 15) == 0) begin
        recv_hold = $urandom_range(1, 10);
      end
      out_stall <= (recv_hold > 0);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_req(8'h00, 1'b1, 1'b1, 8'd0);
    push_req(8'h5A, 1'b0, 1'b1, 8'd255);
    push_req(8'hFF, 1'b1, 1'b0, 8'd255);
    push_req(8'h3E, 1'b0, 1'b0, 8'h00);
    push_req(8'h00, 1'b0, 1'b1, 8'hFF);
    push_req(8'hC8, 1'b1, 1'b1, 8'd6);
    push_req(STUFF_BYTE, 1'b0, 1'b0, 8'd0);
    repeat (4) push_req(8'h3E, 1'b0, 1'b0, 8'd0);
    push_req(8'h00, 1'b1, 1'b1, 8'd8);
    push_req(8'h3E, 1'b0, 1'b0, 8'd0);
    push_req(8'h00, 1'b0, 1'b0, 8'd0);
    push_req(8'h00, 1'b0, 1'b0, 8'd0);
    push_req(8'h3E, 1'b0, 1'b0, 8'd0);
    push_req(8'hF0, 1'b0, 1'b0, 8'd0);
    push_req(8'h01, 1'b0, 1'b0, 8'd0);
    push_req(8'hA5, 1'b0, 1'b0, 8'd0);
    push_req(8'h01, 1'b1, 1'b1, 8'd4);
    push_req(8'h77, 1'b0, 1'b0, 8'd0);
    push_req(8'h3E, 1'b0, 1'b0, 8'd0);
    push_req(8'h00, 1'b0, 1'b0, 8'd0);
    push_req(8'h05, 1'b1, 1'b0, 8'd3);
    push_req(8'hFF, 1'b0, 1'b1, 8'hFF);
    push_req(8'h00, 1'b0, 1'b0, 8'd0);

    random_traffic(250);
    next_setting(8'h00, 8'h00, 250);
    next_setting(8'hFE, 8'hFF, 250);
    next_setting(8'($urandom_range(0, 254)), 8'($urandom), 250);
    next_setting(8'hFF, PROTOCOL_RST, 100);
    next_setting(TABLE_ID_RST, 8'd6, 250);

    wait_idle(16);
    if (fault_cnt == 0) begin
      $display("mpe_section_ip_extractor_unit_tb: done, clean");
    end else begin
      $display("mpe_section_ip_extractor_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mpe_section_ip_extractor_unit_tb: done, errors");
    $finish;
  end

endmodule
